### hdl/shs_pkg.sv
// ----------------------------------------------------------------------------
// shs_pkg
// Types, constants and the round constant table for the stream hasher.
// ----------------------------------------------------------------------------
package shs_pkg;

  typedef logic [31:0]       word_t;
  typedef logic [0:7][31:0]  work_t;
  typedef logic [0:15][31:0] sched_t;

  localparam int unsigned BLK_BITS = 512;

  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [8:0] LEN_POS  = 9'd448;

  localparam work_t SHS_IV = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } shs_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } shs_out_t;

  function automatic word_t shs_k(input logic [5:0] idx);
    word_t k;
    case (idx)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage

### hdl/shs_round.sv
// ----------------------------------------------------------------------------
// shs_round
// One compression round plus one step of the message schedule window.
// ----------------------------------------------------------------------------
module shs_round
  import shs_pkg::*;
(
  input  work_t  work_i,
  input  sched_t sched_i,
  input  word_t  k_i,
  output work_t  work_o,
  output sched_t sched_o
);

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  word_t big_s0, big_s1, ch, maj, t1, t2, sm0, sm1, w_new;

  always_comb begin
    big_s1 = rotr(work_i[4], 6) ^ rotr(work_i[4], 11) ^ rotr(work_i[4], 25);
    ch     = (work_i[4] & work_i[5]) ^ (~work_i[4] & work_i[6]);
    t1     = work_i[7] + big_s1 + ch + k_i + sched_i[0];
    big_s0 = rotr(work_i[0], 2) ^ rotr(work_i[0], 13) ^ rotr(work_i[0], 22);
    maj    = (work_i[0] & work_i[1]) ^ (work_i[0] & work_i[2]) ^ (work_i[1] & work_i[2]);
    t2     = big_s0 + maj;

    work_o[0] = t1 + t2;
    work_o[1] = work_i[0];
    work_o[2] = work_i[1];
    work_o[3] = work_i[2];
    work_o[4] = work_i[3] + t1;
    work_o[5] = work_i[4];
    work_o[6] = work_i[5];
    work_o[7] = work_i[6];

    // window holds w[r..r+15], slide by one and append w[r+16]
    sm0   = rotr(sched_i[1], 7) ^ rotr(sched_i[1], 18) ^ (sched_i[1] >> 3);
    sm1   = rotr(sched_i[14], 17) ^ rotr(sched_i[14], 19) ^ (sched_i[14] >> 10);
    w_new = sched_i[0] + sm0 + sched_i[9] + sm1;
    for (int j = 0; j < 15; j++) begin
      sched_o[j] = sched_i[j+1];
    end
    sched_o[15] = w_new;
  end

endmodule

### hdl/sha256_stream_hasher_core.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher_core
// Byte-serial SHA-256 hasher with one shared round unit.
// ----------------------------------------------------------------------------
// An absorb request takes its byte straight into the block; the 64th byte of a
// block then starts a compression of 64 rounds through the single round unit,
// followed by a fold of the result into the chaining words. A finish request
// feeds the padding (0x80, zeros, 64-bit length) through the same byte path at
// one byte per cycle, paused while one or two compressions run, 9 to 72 bytes,
// and then presents the eight digest words in order, word 0 first. The input
// stalls while a compression and its fold run, and from a finish until the
// digest has been taken; the hash state then returns to its initial values.
module sha256_stream_hasher_core
  import shs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  shs_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output shs_out_t out_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_PAD, S_COMP, S_FOLD, S_OUT
  } state_t;

  state_t      state_r, state_nxt;
  state_t      ret_r, ret_nxt;
  work_t       chain_r, chain_nxt;
  work_t       work_r, work_nxt;
  sched_t      blk_r, blk_nxt;
  logic [63:0] bit_cnt_r, bit_cnt_nxt;
  logic [63:0] len_r, len_nxt;
  logic [3:0]  len_cnt_r, len_cnt_nxt;
  logic        pad_first_r, pad_first_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic [2:0]  out_idx_r, out_idx_nxt;

  logic                 do_abs;
  logic [7:0]           abs_byte;
  logic [BLK_BITS-1:0]  blk_flat;
  work_t                rnd_work;
  sched_t               rnd_sched;

  shs_round u_round (
    .work_i  (work_r),
    .sched_i (blk_r),
    .k_i     (shs_k(rnd_r)),
    .work_o  (rnd_work),
    .sched_o (rnd_sched)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    out_data.digest_word = chain_r[out_idx_r];
    out_data.word_index  = out_idx_r;
    out_data.last_word   = (out_idx_r == 3'd7);
  end

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    chain_nxt     = chain_r;
    work_nxt      = work_r;
    blk_nxt       = blk_r;
    bit_cnt_nxt   = bit_cnt_r;
    len_nxt       = len_r;
    len_cnt_nxt   = len_cnt_r;
    pad_first_nxt = pad_first_r;
    rnd_nxt       = rnd_r;
    out_idx_nxt   = out_idx_r;
    do_abs        = 1'b0;
    abs_byte      = '0;
    blk_flat      = blk_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.op == OP_FINISH) begin
            len_nxt       = bit_cnt_r;
            len_cnt_nxt   = '0;
            pad_first_nxt = 1'b1;
            state_nxt     = S_PAD;
          end else begin
            do_abs   = 1'b1;
            abs_byte = in_data.data_byte;
            ret_nxt  = S_IDLE;
          end
        end
      end
      S_PAD: begin
        do_abs  = 1'b1;
        ret_nxt = S_PAD;
        if (pad_first_r) begin
          abs_byte      = PAD_BYTE;
          pad_first_nxt = 1'b0;
        end else if (len_cnt_r != 4'd0 || bit_cnt_r[8:0] == LEN_POS) begin
          // length bytes, most significant first
          abs_byte    = len_r[63:56];
          len_nxt     = {len_r[55:0], 8'h00};
          len_cnt_nxt = len_cnt_r + 4'd1;
          if (len_cnt_r == 4'd7) begin
            ret_nxt = S_OUT;
          end
        end
      end
      S_COMP: begin
        work_nxt = rnd_work;
        blk_nxt  = rnd_sched;
        rnd_nxt  = rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          state_nxt = S_FOLD;
        end
      end
      S_FOLD: begin
        for (int j = 0; j < 8; j++) begin
          chain_nxt[j] = chain_r[j] + work_r[j];
        end
        out_idx_nxt = '0;
        state_nxt   = ret_r;
      end
      S_OUT: begin
        if (!out_stall) begin
          out_idx_nxt = out_idx_r + 3'd1;
          if (out_idx_r == 3'd7) begin
            chain_nxt   = SHS_IV;
            bit_cnt_nxt = '0;
            state_nxt   = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (do_abs) begin
      // bytes shift in big-endian, word 0 ends up in the first slot
      blk_nxt     = sched_t'({blk_flat[BLK_BITS-9:0], abs_byte});
      bit_cnt_nxt = bit_cnt_r + 64'd8;
      if (bit_cnt_r[8:3] == 6'd63) begin
        work_nxt  = chain_r;
        rnd_nxt   = '0;
        state_nxt = S_COMP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      chain_r     <= SHS_IV;
      bit_cnt_r   <= '0;
      len_cnt_r   <= '0;
      pad_first_r <= 1'b0;
      rnd_r       <= '0;
      out_idx_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      chain_r     <= chain_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      len_cnt_r   <= len_cnt_nxt;
      pad_first_r <= pad_first_nxt;
      rnd_r       <= rnd_nxt;
      out_idx_r   <= out_idx_nxt;
    end
    work_r <= work_nxt;
    blk_r  <= blk_nxt;
    len_r  <= len_nxt;
  end

endmodule
